### hdl/tea_pkg.sv
package tea_pkg;

    localparam int unsigned TEA_ROUNDS     = 32;
    localparam int unsigned TEA_WORD_WIDTH = 32;
    localparam logic [TEA_WORD_WIDTH-1:0] TEA_DELTA = 32'h9e37_79b9;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_KEY_WORD0    = 3'd0,
        CFG_KEY_WORD1    = 3'd1,
        CFG_KEY_WORD2    = 3'd2,
        CFG_KEY_WORD3    = 3'd3,
        CFG_DECRYPT_MODE = 3'd4
    } tea_cfg_index_t;

    typedef logic [TEA_WORD_WIDTH-1:0] tea_word_t;

    typedef struct packed {
        tea_word_t block_word0;
        tea_word_t block_word1;
    } tea_block_t;

    typedef struct packed {
        tea_word_t result_word0;
        tea_word_t result_word1;
    } tea_result_t;

    // Key words already ordered for the first and second half-round of each round
    typedef struct packed {
        logic      decrypt;
        tea_word_t ka_first;
        tea_word_t kb_first;
        tea_word_t ka_second;
        tea_word_t kb_second;
    } tea_keys_t;

    function automatic tea_word_t tea_mix(
        input tea_word_t v,
        input tea_word_t sum,
        input tea_word_t ka,
        input tea_word_t kb
    );
        tea_word_t shl;
        tea_word_t shr;
        shl = v << 4;
        shr = v >> 5;
        return (shl + ka) ^ (v + sum) ^ (shr + kb);
    endfunction

endpackage

### hdl/tea_round.sv
module tea_round
    import tea_pkg::*;
#(
    parameter tea_word_t ENC_SUM = TEA_DELTA,
    parameter tea_word_t DEC_SUM = TEA_DELTA
)(
    input  logic      clk,
    input  logic      rst_n,
    input  tea_keys_t keys,
    input  logic      valid,
    input  tea_word_t word_x,
    input  tea_word_t word_y,
    output logic      round_valid,
    output tea_word_t round_x,
    output tea_word_t round_y
);

    tea_word_t sum;
    tea_word_t mix_a;
    tea_word_t mix_b;

    logic      valid_a_reg;
    tea_word_t x_a_reg;
    tea_word_t x_a_next;
    tea_word_t y_a_reg;

    logic      valid_b_reg;
    tea_word_t x_b_reg;
    tea_word_t y_b_reg;
    tea_word_t y_b_next;

    assign sum = keys.decrypt ? DEC_SUM : ENC_SUM;

    // First half-round: update x from y
    always_comb
    begin
        mix_a    = tea_mix(word_y, sum, keys.ka_first, keys.kb_first);
        x_a_next = keys.decrypt ? (word_x - mix_a) : (word_x + mix_a);
    end

    // Second half-round: update y from the new x
    always_comb
    begin
        mix_b    = tea_mix(x_a_reg, sum, keys.ka_second, keys.kb_second);
        y_b_next = keys.decrypt ? (y_a_reg - mix_b) : (y_a_reg + mix_b);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end
        else
        begin
            valid_a_reg <= valid;
            valid_b_reg <= valid_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        x_a_reg <= x_a_next;
        y_a_reg <= word_y;
        x_b_reg <= x_a_reg;
        y_b_reg <= y_b_next;
    end

    assign round_valid = valid_b_reg;
    assign round_x     = x_b_reg;
    assign round_y     = y_b_reg;

endmodule

### hdl/tea_block_cipher.sv
// TEA block cipher, fully unrolled pipeline.
//
// Input: drive block and raise start; a block transfers at every rising edge
// with start high and busy low. busy stays low, so a new block may transfer
// in every cycle.
// Output: done strobes for one cycle while result holds the enciphered (or
// deciphered) block. The receiver has no way to stall; results come out in
// the order the blocks went in.
// Pipeline: one half-round sits between each pair of pipeline registers,
// giving one block per cycle of sustained throughput.
// Configuration: cfg_we writes cfg_data into the register picked by
// cfg_index (four key words, then decrypt_mode); unknown indexes drop the
// write. Write only while no block is in flight.
// Reset: rst_n clears the keys, selects encryption and drops every block in
// flight, so no done follows a block taken before reset.
module tea_block_cipher
    import tea_pkg::*;
#(
    parameter int unsigned ROUNDS = TEA_ROUNDS
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  tea_block_t  block,
    output logic        done,
    output tea_result_t result,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  tea_word_t   cfg_data
);

    tea_word_t key0_reg;
    tea_word_t key0_next;
    tea_word_t key1_reg;
    tea_word_t key1_next;
    tea_word_t key2_reg;
    tea_word_t key2_next;
    tea_word_t key3_reg;
    tea_word_t key3_next;
    logic      decrypt_reg;
    logic      decrypt_next;

    tea_keys_t keys;

    // Pipeline links: entry at index 0, one round module per step
    logic      lane_valid [ROUNDS+1];
    tea_word_t lane_x     [ROUNDS+1];
    tea_word_t lane_y     [ROUNDS+1];

    // Configuration register file
    always_comb
    begin
        key0_next    = key0_reg;
        key1_next    = key1_reg;
        key2_next    = key2_reg;
        key3_next    = key3_reg;
        decrypt_next = decrypt_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_KEY_WORD0:    key0_next    = cfg_data;
                CFG_KEY_WORD1:    key1_next    = cfg_data;
                CFG_KEY_WORD2:    key2_next    = cfg_data;
                CFG_KEY_WORD3:    key3_next    = cfg_data;
                CFG_DECRYPT_MODE: decrypt_next = cfg_data[0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key0_reg    <= '0;
            key1_reg    <= '0;
            key2_reg    <= '0;
            key3_reg    <= '0;
            decrypt_reg <= 1'b0;
        end
        else
        begin
            key0_reg    <= key0_next;
            key1_reg    <= key1_next;
            key2_reg    <= key2_next;
            key3_reg    <= key3_next;
            decrypt_reg <= decrypt_next;
        end
    end

    // Decryption walks the round in reverse: swap the words so every
    // round module updates x first, then y, and swap the key pairs to match.
    always_comb
    begin
        keys.decrypt   = decrypt_reg;
        keys.ka_first  = decrypt_reg ? key2_reg : key0_reg;
        keys.kb_first  = decrypt_reg ? key3_reg : key1_reg;
        keys.ka_second = decrypt_reg ? key0_reg : key2_reg;
        keys.kb_second = decrypt_reg ? key1_reg : key3_reg;
    end

    // Always ready: the pipeline never holds back
    assign busy = 1'b0;

    assign lane_valid[0] = start && !busy;
    assign lane_x[0]     = decrypt_reg ? block.block_word1 : block.block_word0;
    assign lane_y[0]     = decrypt_reg ? block.block_word0 : block.block_word1;

    for (genvar r = 0; r < ROUNDS; r++)
    begin : g_round
        // Running sum of round r, fixed per stage at elaboration
        localparam tea_word_t ENC_SUM = 32'(TEA_DELTA * 32'(r + 1));
        localparam tea_word_t DEC_SUM = 32'(TEA_DELTA * 32'(ROUNDS - r));

        tea_round #(
            .ENC_SUM (ENC_SUM),
            .DEC_SUM (DEC_SUM)
        ) u_round (
            .clk         (clk),
            .rst_n       (rst_n),
            .keys        (keys),
            .valid       (lane_valid[r]),
            .word_x      (lane_x[r]),
            .word_y      (lane_y[r]),
            .round_valid (lane_valid[r+1]),
            .round_x     (lane_x[r+1]),
            .round_y     (lane_y[r+1])
        );
    end

    // Swap back on the way out; the last round register is the output register
    assign done                = lane_valid[ROUNDS];
    assign result.result_word0 = decrypt_reg ? lane_y[ROUNDS] : lane_x[ROUNDS];
    assign result.result_word1 = decrypt_reg ? lane_x[ROUNDS] : lane_y[ROUNDS];

endmodule

### hdl/tea_checker.sv
module tea_checker
    import tea_pkg::*;
#(
    parameter int unsigned ROUNDS = TEA_ROUNDS
)(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);

    localparam int unsigned LATENCY = 2 * ROUNDS;

    // Pipeline takes a block every cycle
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised on a fully pipelined block");

    // Every transfer is followed by a matching done
    a_transfer_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("accepted block produced no result on time");

    // No result without a matching transfer
    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without a matching transfer");

endmodule

bind tea_block_cipher tea_checker #(
    .ROUNDS (ROUNDS)
) u_tea_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);

### dv/tb_tea_block_cipher.sv
`timescale 1ns / 1ps

module tb_tea_block_cipher;
    import tea_pkg::*;

    // Stop the run well past the slowest legal finish (random idling before each
    // block, plus one pipeline flush per key/mode setting).
    localparam int unsigned CYCLE_LIMIT    = 400000;
    localparam int unsigned PIPE_LATENCY   = 2 * TEA_ROUNDS;
    localparam int unsigned IDLE_PCT       = 13;
    localparam int unsigned RANDOM_PHASES  = 10;
    localparam int unsigned PHASE_BLOCKS   = 170;
    localparam int unsigned STREAM_BLOCKS  = 64;
    localparam int unsigned MAX_REPORTED   = 30;

    // Published TEA vector: all-zero key and block.
    localparam tea_word_t KAT_WORD0 = 32'h41ea_3a0a;
    localparam tea_word_t KAT_WORD1 = 32'h94ba_a940;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        start     = 1'b0;
    logic        busy;
    tea_block_t  block     = '0;
    logic        done;
    tea_result_t result;
    logic        cfg_we    = 1'b0;
    logic [2:0]  cfg_index = '0;
    tea_word_t   cfg_data  = '0;

    // Shadow copy of the configuration registers, updated at each write edge.
    tea_word_t   key_shadow [4];
    logic        decrypt_shadow;

    // Ciphered blocks still in the pipeline, oldest first.
    tea_result_t pending_ciphertexts [$];
    tea_result_t oldest_pending;

    int unsigned idle_pct        = IDLE_PCT;
    int unsigned blocks_sent     = 0;
    int unsigned results_checked = 0;
    int unsigned mismatch_count  = 0;
    int unsigned settings_loaded = 0;
    int unsigned reg_writes      = 0;
    int unsigned decrypt_blocks  = 0;
    int unsigned cycle_count     = 0;

    tea_block_cipher dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .block     (block),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Bound the run: a hung pipeline or a lost result ends here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_ciphertexts.size());
            $display("tea_block_cipher regression: fail");
            $finish;
        end
    end

    // Print one line per mismatch (up to a cap) and count every one.
    task automatic report_mismatch(input string what, input tea_word_t got,
                                   input tea_word_t want);
        if (mismatch_count < MAX_REPORTED)
            $display("[%0t] mismatch, %s: got %h expected %h", $time, what, got, want);
        mismatch_count++;
    endtask

    // One TEA half-round mixing function, mod 2^32.
    function automatic tea_word_t feistel_mix(input tea_word_t v, input tea_word_t running_sum,
                                              input tea_word_t ka, input tea_word_t kb);
        tea_word_t left_part;
        tea_word_t right_part;
        left_part  = {v[TEA_WORD_WIDTH-5:0], 4'b0000} + ka;
        right_part = {5'b00000, v[TEA_WORD_WIDTH-1:5]} + kb;
        return left_part ^ (v + running_sum) ^ right_part;
    endfunction

    // Encipher or decipher one block under the shadow key and mode.
    function automatic tea_result_t predict_ciphertext(input tea_block_t blk);
        tea_word_t   v0;
        tea_word_t   v1;
        tea_word_t   running_sum;
        tea_result_t res;
        int          r;
        v0 = blk.block_word0;
        v1 = blk.block_word1;
        if (!decrypt_shadow)
        begin
            running_sum = '0;
            for (r = 0; r < TEA_ROUNDS; r++)
            begin
                running_sum = running_sum + TEA_DELTA;
                v0 = v0 + feistel_mix(v1, running_sum, key_shadow[0], key_shadow[1]);
                v1 = v1 + feistel_mix(v0, running_sum, key_shadow[2], key_shadow[3]);
            end
        end
        else
        begin
            running_sum = TEA_DELTA * TEA_ROUNDS;
            for (r = 0; r < TEA_ROUNDS; r++)
            begin
                v1 = v1 - feistel_mix(v0, running_sum, key_shadow[2], key_shadow[3]);
                v0 = v0 - feistel_mix(v1, running_sum, key_shadow[0], key_shadow[1]);
                running_sum = running_sum - TEA_DELTA;
            end
        end
        res.result_word0 = v0;
        res.result_word1 = v1;
        return res;
    endfunction

    // Mirror a register write; unknown indexes drop it, mode keeps bit 0 only.
    function automatic void apply_reg(input logic [2:0] idx, input tea_word_t data);
        case (idx)
            CFG_KEY_WORD0:    key_shadow[0]  = data;
            CFG_KEY_WORD1:    key_shadow[1]  = data;
            CFG_KEY_WORD2:    key_shadow[2]  = data;
            CFG_KEY_WORD3:    key_shadow[3]  = data;
            CFG_DECRYPT_MODE: decrypt_shadow = data[0];
            default:          ;
        endcase
    endfunction

    // Biased word: all zeros, all ones, a single set bit, or fully random.
    function automatic tea_word_t pick_word();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return tea_word_t'(1) << $urandom_range(TEA_WORD_WIDTH - 1);
            default: return $urandom;
        endcase
    endfunction

    // Append one expected result behind those already in flight.
    function automatic void queue_expected(input tea_result_t expected);
        pending_ciphertexts = {pending_ciphertexts, expected};
    endfunction

    // Check each result in the cycle it is presented; the receiver cannot stall.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_ciphertexts.size() == 0)
                report_mismatch("result with no block in flight", result.result_word0, '0);
            else
            begin
                oldest_pending = pending_ciphertexts.pop_front();
                if (result.result_word0 !== oldest_pending.result_word0)
                    report_mismatch("result_word0", result.result_word0,
                                    oldest_pending.result_word0);
                if (result.result_word1 !== oldest_pending.result_word1)
                    report_mismatch("result_word1", result.result_word1,
                                    oldest_pending.result_word1);
                results_checked++;
            end
        end
    end

    // Write one register, then drop the enable before returning.
    task automatic write_reg(input logic [2:0] idx, input tea_word_t data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        apply_reg(idx, data);
        reg_writes++;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Load all four key words and the mode word (upper mode bits are junk).
    task automatic load_settings(input tea_word_t k0, input tea_word_t k1,
                                 input tea_word_t k2, input tea_word_t k3,
                                 input tea_word_t mode_word);
        write_reg(CFG_KEY_WORD0, k0);
        write_reg(CFG_KEY_WORD1, k1);
        write_reg(CFG_KEY_WORD2, k2);
        write_reg(CFG_KEY_WORD3, k3);
        write_reg(CFG_DECRYPT_MODE, mode_word);
        settings_loaded++;
    endtask

    // Transfer one block: idle at random first, hold start until taken.
    // start is left high after the transfer so a following block streams
    // without a gap; idling or draining lowers it.
    task automatic send_block(input tea_word_t w0, input tea_word_t w1);
        tea_block_t blk;
        blk.block_word0 = w0;
        blk.block_word1 = w1;
        while (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            block <= {$urandom, $urandom};
            @(posedge clk);
        end
        start <= 1'b1;
        block <= blk;
        do
            @(posedge clk);
        while (busy);
        queue_expected(predict_ciphertext(blk));
        blocks_sent++;
        if (decrypt_shadow)
            decrypt_blocks++;
    endtask

    // Drop start and let the pipeline empty before touching the registers.
    task automatic wait_for_results();
        start <= 1'b0;
        while (pending_ciphertexts.size() != 0)
            @(posedge clk);
    endtask

    // Reset values: zero key, encrypt. Run the word extremes through it.
    task automatic test_reset_defaults();
        tea_block_t  zero_blk;
        tea_result_t kat;
        wait_for_results();
        zero_blk = '0;
        kat = predict_ciphertext(zero_blk);
        if (kat.result_word0 !== KAT_WORD0)
            report_mismatch("zero-key vector word0", kat.result_word0, KAT_WORD0);
        if (kat.result_word1 !== KAT_WORD1)
            report_mismatch("zero-key vector word1", kat.result_word1, KAT_WORD1);
        send_block('0, '0);
        send_block('1, '1);
        send_block('0, '1);
        send_block('1, '0);
        send_block(32'h8000_0000, 32'h0000_0001);
        send_block(32'haaaa_aaaa, 32'h5555_5555);
    endtask

    // All-ones key in both modes, then zero key in decrypt; the all-ones mode writes carry junk above bit 0.
    task automatic test_key_extremes();
        wait_for_results();
        load_settings('1, '1, '1, '1, 32'hffff_fffe);
        send_block('0, '0);
        send_block('1, '1);
        send_block(32'h0000_0001, 32'h8000_0000);
        wait_for_results();
        // decrypt: bit 0 set with every upper bit set too
        write_reg(CFG_DECRYPT_MODE, '1);
        send_block('0, '0);
        send_block('1, '1);
        send_block(KAT_WORD0, KAT_WORD1);
        wait_for_results();
        // zero key in decrypt mode takes the published vector back to zero
        load_settings('0, '0, '0, '0, 32'h0000_0001);
        send_block(KAT_WORD0, KAT_WORD1);
        send_block('1, '0);
    endtask

    // Writes to indexes past the last register must leave the settings alone.
    task automatic test_unused_indexes();
        int i;
        wait_for_results();
        load_settings(32'h0123_4567, 32'h89ab_cdef, 32'hfedc_ba98, 32'h7654_3210, '0);
        for (i = int'(CFG_DECRYPT_MODE) + 1; i < (1 << $bits(cfg_index)); i++)
            write_reg(i[2:0], '1);
        send_block('0, '0);
        send_block(32'hdead_beef, 32'hcafe_f00d);
        send_block('1, '1);
    endtask

    // Fill the pipeline: one transfer per cycle, no gaps.
    task automatic test_full_stream();
        int n;
        wait_for_results();
        load_settings(pick_word(), pick_word(), pick_word(), pick_word(), $urandom);
        idle_pct = 0;
        for (n = 0; n < STREAM_BLOCKS; n++)
            send_block(pick_word(), pick_word());
        idle_pct = IDLE_PCT;
    endtask

    // Random blocks under a series of key/mode settings, extremes first.
    task automatic test_random_traffic();
        int phase;
        int n;
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wait_for_results();
            case (phase)
                0:       load_settings('1, '1, '1, '1, $urandom);
                1:       load_settings('0, '0, '0, '0, $urandom);
                default: load_settings(pick_word(), pick_word(), pick_word(), pick_word(),
                                       $urandom);
            endcase
            // one phase runs with no idling at all
            idle_pct = (phase == 4) ? 0 : IDLE_PCT;
            for (n = 0; n < PHASE_BLOCKS; n++)
                send_block(pick_word(), pick_word());
        end
        idle_pct = IDLE_PCT;
    endtask

    initial
    begin
        key_shadow[0]  = '0;
        key_shadow[1]  = '0;
        key_shadow[2]  = '0;
        key_shadow[3]  = '0;
        decrypt_shadow = 1'b0;

        // Hold reset from time zero, then release it once.
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_key_extremes();
        test_unused_indexes();
        test_full_stream();
        test_random_traffic();

        // Drain, then give any stray result a full pipeline depth to show up.
        wait_for_results();
        repeat (PIPE_LATENCY + 16) @(posedge clk);

        $display("sent %0d blocks (%0d deciphered) over %0d key/mode settings, %0d writes",
                 blocks_sent, decrypt_blocks, settings_loaded, reg_writes);
        $display("checked %0d results, %0d mismatches", results_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("tea_block_cipher regression: pass");
        else
            $display("tea_block_cipher regression: fail");
        $finish;
    end

endmodule

### tea_block_cipher.f
hdl/tea_pkg.sv
hdl/tea_round.sv
hdl/tea_block_cipher.sv
hdl/tea_checker.sv
dv/tb_tea_block_cipher.sv
